// File: rtl/cabb_pkg.sv
// ----------------------------------------------------------------------------
// cabb_pkg
// shared types and constants of the clipped alpha blend blit
// ----------------------------------------------------------------------------
package cabb_pkg;

   localparam int FB_WIDTH     = 1024;
   localparam int FB_HEIGHT    = 1024;
   localparam int FB_ROW_WORDS = 1024;

   localparam int REG_WIDTH   = 13;
   localparam int COUNT_WIDTH = 12;
   localparam int POS_WIDTH   = 16;
   localparam int ADDR_WIDTH  = 20;
   localparam int RGB_WIDTH   = 24;
   localparam int CSR_IDX_W   = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

   localparam logic [REG_WIDTH-1:0] MAX_SIZE = REG_WIDTH'(4096);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEST_X       = 4'd0,
      CSR_DEST_Y       = 4'd1,
      CSR_IMAGE_WIDTH  = 4'd2,
      CSR_IMAGE_HEIGHT = 4'd3,
      CSR_CLIP_LEFT    = 4'd4,
      CSR_CLIP_TOP     = 4'd5,
      CSR_CLIP_WIDTH   = 4'd6,
      CSR_CLIP_HEIGHT  = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [31:0] source_pixel;
      logic [31:0] background_pixel;
   } req_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] write_address;
      logic [RGB_WIDTH-1:0]  write_pixel;
   } rsp_type;

   typedef struct packed {
      logic [7:0]            alpha;
      logic [RGB_WIDTH-1:0]  src_rgb;
      logic [RGB_WIDTH-1:0]  bg_rgb;
      logic [ADDR_WIDTH-1:0] addr;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: rtl/cabb_front.sv
// ----------------------------------------------------------------------------
// cabb_front
// config registers, raster counters and visibility test; queues visible pixels of nonzero alpha as work
// ----------------------------------------------------------------------------
module cabb_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cabb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cabb_pkg::REG_WIDTH-1:0]       csr_data,
   input  logic                                 req_push,
   input  cabb_pkg::req_type                    req_data,
   output logic                                 req_full,
   input  cabb_pkg::queue_status_type           q_status,
   output logic                                 work_push,
   output cabb_pkg::work_type                   work_data
);

   logic signed [cabb_pkg::REG_WIDTH-1:0] dest_x_ff, dest_y_ff, clip_left_ff, clip_top_ff;
   logic [cabb_pkg::REG_WIDTH-1:0] image_width_ff, image_height_ff;
   logic [cabb_pkg::REG_WIDTH-1:0] clip_width_ff, clip_height_ff;
   logic [cabb_pkg::COUNT_WIDTH-1:0] column_ff, column_in, row_ff, row_in;

   logic [cabb_pkg::REG_WIDTH-1:0] w_eff, h_eff;
   logic signed [cabb_pkg::POS_WIDTH-1:0] px, py, cl, ct, cr, cb, fb_w, fb_h;
   logic [31:0] addr_full;
   logic        accept, visible, col_last, row_last;

   assign csr_ready = 1'b1;
   assign req_full  = q_status.full;
   assign accept    = req_push && !q_status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff       <= '0;
         dest_y_ff       <= '0;
         image_width_ff  <= cabb_pkg::REG_WIDTH'(1);
         image_height_ff <= cabb_pkg::REG_WIDTH'(1);
         clip_left_ff    <= '0;
         clip_top_ff     <= '0;
         clip_width_ff   <= cabb_pkg::REG_WIDTH'(1024);
         clip_height_ff  <= cabb_pkg::REG_WIDTH'(1024);
      end else if (csr_valid) begin
         case (cabb_pkg::csr_index_type'(csr_index))
            cabb_pkg::CSR_DEST_X:       dest_x_ff       <= csr_data;
            cabb_pkg::CSR_DEST_Y:       dest_y_ff       <= csr_data;
            cabb_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            cabb_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_data;
            cabb_pkg::CSR_CLIP_LEFT:    clip_left_ff    <= csr_data;
            cabb_pkg::CSR_CLIP_TOP:     clip_top_ff     <= csr_data;
            cabb_pkg::CSR_CLIP_WIDTH:   clip_width_ff   <= csr_data;
            cabb_pkg::CSR_CLIP_HEIGHT:  clip_height_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // effective image size, zero counts as one, sizes above MAX_SIZE clamp to MAX_SIZE
   always_comb begin
      if (image_width_ff == '0)
         w_eff = cabb_pkg::REG_WIDTH'(1);
      else if (image_width_ff > cabb_pkg::MAX_SIZE)
         w_eff = cabb_pkg::MAX_SIZE;
      else
         w_eff = image_width_ff;
      if (image_height_ff == '0)
         h_eff = cabb_pkg::REG_WIDTH'(1);
      else if (image_height_ff > cabb_pkg::MAX_SIZE)
         h_eff = cabb_pkg::MAX_SIZE;
      else
         h_eff = image_height_ff;
   end

   assign col_last = ({1'b0, column_ff} + cabb_pkg::REG_WIDTH'(1)) >= w_eff;
   assign row_last = ({1'b0, row_ff} + cabb_pkg::REG_WIDTH'(1)) >= h_eff;

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (col_last) begin
            column_in = '0;
            row_in    = row_last ? '0 : row_ff + cabb_pkg::COUNT_WIDTH'(1);
         end else begin
            column_in = column_ff + cabb_pkg::COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   // framebuffer position and clip bounds
   assign px   = cabb_pkg::POS_WIDTH'(dest_x_ff) + signed'({4'b0, column_ff});
   assign py   = cabb_pkg::POS_WIDTH'(dest_y_ff) + signed'({4'b0, row_ff});
   assign cl   = cabb_pkg::POS_WIDTH'(clip_left_ff);
   assign ct   = cabb_pkg::POS_WIDTH'(clip_top_ff);
   assign cr   = cl + signed'({3'b0, clip_width_ff});
   assign cb   = ct + signed'({3'b0, clip_height_ff});
   assign fb_w = cabb_pkg::POS_WIDTH'(cabb_pkg::FB_WIDTH);
   assign fb_h = cabb_pkg::POS_WIDTH'(cabb_pkg::FB_HEIGHT);

   assign visible = (px >= cl) && (px < cr) && (py >= ct) && (py < cb) &&
                    (px >= 0) && (px < fb_w) && (py >= 0) && (py < fb_h);

   assign addr_full = 32'(py) * 32'(cabb_pkg::FB_ROW_WORDS) + 32'(px);

   assign work_push           = accept && visible && (req_data.source_pixel[31:24] != 8'd0);
   assign work_data.alpha     = req_data.source_pixel[31:24];
   assign work_data.src_rgb   = req_data.source_pixel[23:0];
   assign work_data.bg_rgb    = req_data.background_pixel[23:0];
   assign work_data.addr      = addr_full[cabb_pkg::ADDR_WIDTH-1:0];

endmodule

// File: rtl/cabb_queue.sv
// ----------------------------------------------------------------------------
// cabb_queue
// short work queue between front and back
// ----------------------------------------------------------------------------
module cabb_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  cabb_pkg::work_type          push_data,
   input  logic                        pop,
   output cabb_pkg::work_type          pop_data,
   output cabb_pkg::queue_status_type  status
);

   cabb_pkg::work_type mem_ff [cabb_pkg::QUEUE_DEPTH];
   logic [cabb_pkg::QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [cabb_pkg::QPTR_WIDTH:0]   count_ff, count_in;
   logic do_push, do_pop;

   assign status.full  = count_ff == (cabb_pkg::QPTR_WIDTH+1)'(cabb_pkg::QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + cabb_pkg::QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + cabb_pkg::QPTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + (cabb_pkg::QPTR_WIDTH+1)'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - (cabb_pkg::QPTR_WIDTH+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: rtl/cabb_back.sv
// ----------------------------------------------------------------------------
// cabb_back
// two-stage blend: channel products, then sum and divide by 255
// ----------------------------------------------------------------------------
module cabb_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                work_avail,
   input  cabb_pkg::work_type  work_data,
   output logic                work_pop,
   output logic                rsp_empty,
   output cabb_pkg::rsp_type   rsp_data,
   input  logic                rsp_pop
);

   logic        s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic        s1_ready, s2_ready;
   logic [2:0][15:0] fg_prod_ff, fg_prod_in, bg_prod_ff, bg_prod_in;
   logic [cabb_pkg::ADDR_WIDTH-1:0] s1_addr_ff;
   cabb_pkg::rsp_type rsp_ff, rsp_in;

   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'd1 + 17'(x[15:8]);
      return t[15:8];
   endfunction

   assign s2_ready    = !s2_valid_ff || rsp_pop;
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign work_pop    = work_avail && s1_ready;
   assign s1_valid_in = s1_ready ? work_avail : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fg_prod_in[i] = 16'(work_data.src_rgb[8*i +: 8]) * 16'(work_data.alpha);
         bg_prod_in[i] = 16'(work_data.bg_rgb[8*i +: 8]) * 16'(8'd255 - work_data.alpha);
      end
   end

   always_comb begin
      rsp_in.write_address = s1_addr_ff;
      for (int i = 0; i < 3; i++)
         rsp_in.write_pixel[8*i +: 8] = div255(fg_prod_ff[i] + bg_prod_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         fg_prod_ff <= fg_prod_in;
         bg_prod_ff <= bg_prod_in;
         s1_addr_ff <= work_data.addr;
      end
      if (s2_ready)
         rsp_ff <= rsp_in;
   end

   assign rsp_empty = !s2_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/clipped_alpha_blend_blit_top.sv
// ----------------------------------------------------------------------------
// clipped_alpha_blend_blit_top
// clipped argb8888 alpha blend blit, one pixel per clock while req_full is low
//
//   port group  direction  handshake            payload
//   req_        in         req_push / req_full  source and background pixel
//   rsp_        out        rsp_empty / rsp_pop  write address and rgb pixel
//   csr_        in         csr_valid / csr_ready register index and data
//
// one pixel accepted per cycle while req_full is low; the front classifies it in the accept cycle
// a written pixel passes the queue entry, the product stage and the result
// register on its way to rsp_; the four-entry work queue sets the slack
// reset is synchronous, no clearing pass
// req_full rises only when the work queue fills under a stalled rsp_pop
// ----------------------------------------------------------------------------
module clipped_alpha_blend_blit_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  cabb_pkg::req_type              req_data,
   output logic                           req_full,
   output logic                           rsp_empty,
   output cabb_pkg::rsp_type              rsp_data,
   input  logic                           rsp_pop,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cabb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cabb_pkg::REG_WIDTH-1:0] csr_data
);

   cabb_pkg::queue_status_type q_status;
   cabb_pkg::work_type         push_work, pop_work;
   logic                       work_push, work_pop;

   cabb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .q_status  (q_status),
      .work_push (work_push),
      .work_data (push_work)
   );

   cabb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (push_work),
      .pop       (work_pop),
      .pop_data  (pop_work),
      .status    (q_status)
   );

   cabb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_avail (!q_status.empty),
      .work_data  (pop_work),
      .work_pop   (work_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data),
      .rsp_pop    (rsp_pop)
   );

`ifndef NO_ASSERTIONS
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("work queue full and empty at once");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      work_push |-> !q_status.full)
      else $error("work pushed into a full queue");

   a_pop_avail: assert property (@(posedge clock) disable iff (reset)
      work_pop |-> !q_status.empty)
      else $error("work popped from an empty queue");
`endif

endmodule
